// ----- rtl/fdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// fdsa_pkg: shared types for the Forth data stack and ALU
// Command codes, result codes, beat payloads and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
package fdsa_pkg;

  // Forth words; codes above CMD_EQ are no-ops.
  typedef enum logic [4:0] {
    CMD_PUSH  = 5'd0,
    CMD_MUL   = 5'd1,
    CMD_DIV   = 5'd2,
    CMD_ADD   = 5'd3,
    CMD_SUB   = 5'd4,
    CMD_MOD   = 5'd5,
    CMD_DUP   = 5'd6,
    CMD_DROP  = 5'd7,
    CMD_PRINT = 5'd8,
    CMD_SWAP  = 5'd9,
    CMD_ROT   = 5'd10,
    CMD_OVER  = 5'd11,
    CMD_EMIT  = 5'd12,
    CMD_CR    = 5'd13,
    CMD_LT    = 5'd14,
    CMD_GT    = 5'd15,
    CMD_EQ    = 5'd16
  } fdsa_cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_DIVZ  = 2'd2,
    ST_OVER  = 2'd3
  } fdsa_status_e;

  typedef enum logic [1:0] {
    PK_NONE = 2'd0,
    PK_NUM  = 2'd1,
    PK_CHAR = 2'd2,
    PK_NL   = 2'd3
  } fdsa_kind_e;

  // Stack position relative to the current count: the free slot, or one,
  // two or three entries below it.
  typedef enum logic [1:0] {
    POS_TOP = 2'd0,
    POS_M1  = 2'd1,
    POS_M2  = 2'd2,
    POS_M3  = 2'd3
  } fdsa_pos_e;

  typedef enum logic [2:0] {
    SRC_LIT    = 3'd0,
    SRC_FIRST  = 3'd1,
    SRC_SECOND = 3'd2,
    SRC_THIRD  = 3'd3,
    SRC_RES    = 3'd4
  } fdsa_src_e;

  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } fdsa_cnt_e;

  typedef enum logic [2:0] {
    S_IDLE    = 3'd0,
    S_CHECK   = 3'd1,
    S_RD_ADDR = 3'd2,
    S_RD_DATA = 3'd3,
    S_EXEC    = 3'd4,
    S_DIV     = 3'd5,
    S_WR      = 3'd6,
    S_DONE    = 3'd7
  } fdsa_state_e;

  typedef struct packed {
    logic [4:0]         command;
    logic signed [31:0] literal;
  } fdsa_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [1:0]         print_kind;
    logic signed [31:0] print_value;
    logic [6:0]         stack_depth;
  } fdsa_out_t;

  // Controller to datapath.
  typedef struct packed {
    logic         ld_item;
    logic         rd_en;
    fdsa_pos_e    rd_pos;
    logic         cap_en;
    logic [1:0]   cap_sel;
    logic         div_start;
    logic         alu_en;
    logic         wr_en;
    fdsa_pos_e    wr_pos;
    fdsa_src_e    wr_src;
    logic         fin;
    fdsa_status_e fin_status;
    fdsa_kind_e   fin_kind;
    fdsa_cnt_e    cnt_op;
  } fdsa_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [4:0] command;
    logic       cnt_ge1;
    logic       cnt_ge2;
    logic       cnt_ge3;
    logic       cnt_full;
    logic       first_zero;
    logic       div_done;
    logic       out_free;
  } fdsa_sts_t;

  function automatic logic [1:0] pos_offset(input fdsa_pos_e pos);
    logic [1:0] off;
    case (pos)
      POS_TOP: off = 2'd0;
      POS_M1:  off = 2'd1;
      POS_M2:  off = 2'd2;
      POS_M3:  off = 2'd3;
      default: off = 2'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/fdsa_ram.sv -----
// ----------------------------------------------------------------------------
// fdsa_ram: generic single-port-write RAM with registered read
// One write and one read address per cycle; no reset on the contents.
// ----------------------------------------------------------------------------
module fdsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fdsa_div.sv -----
// ----------------------------------------------------------------------------
// fdsa_div: iterative signed divide and remainder
// Restoring division on magnitudes, one quotient bit per cycle, with the
// signs applied at the end. The quotient truncates toward zero and the
// remainder follows the sign of the dividend.
// ----------------------------------------------------------------------------
module fdsa_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_mod_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] result_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic        mod_q, mod_d;
  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic [31:0] mag_a;
  logic [31:0] mag_b;

  assign mag_a  = dividend_i[31] ? (~dividend_i + 32'd1) : dividend_i;
  assign mag_b  = divisor_i[31] ? (~divisor_i + 32'd1) : divisor_i;
  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, den_q};

  // One quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    mod_d  = mod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      rem_d  = 32'd0;
      quo_d  = mag_a;
      den_d  = mag_b;
      mod_d  = is_mod_i;
      neg_d  = is_mod_i ? dividend_i[31] : (dividend_i[31] ^ divisor_i[31]);
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = rem_sh[31:0];
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
    mod_q <= mod_d;
  end

  // Sign correction of the selected magnitude.
  always_comb begin
    logic [31:0] mag;
    mag      = mod_q ? rem_q : quo_q;
    result_o = neg_q ? (~mag + 32'd1) : mag;
  end

  assign done_o = done_q;

endmodule

// ----- rtl/fdsa_dp.sv -----
// ----------------------------------------------------------------------------
// fdsa_dp: Forth stack datapath
// Holds the item, the stack count, the operand registers, the stack RAM,
// the ALU and divider, and the output register.
// ----------------------------------------------------------------------------
module fdsa_dp
  import fdsa_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  fdsa_in_t  in_data_i,
  input  fdsa_ctl_t ctl_i,
  output fdsa_sts_t sts_o,
  input  logic      out_stall_i,
  output logic      out_valid_o,
  output fdsa_out_t out_data_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [4:0]         cmd_q;
  logic [31:0]        lit_q;
  logic [CW-1:0]      count_q, count_d;
  logic signed [31:0] first_q, second_q, third_q;
  logic [31:0]        res_q, res_d;
  logic               out_valid_q;
  fdsa_out_t          out_data_q;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data, rd_data;
  logic               div_done;
  logic [31:0]        div_res;
  logic [31:0]        pval;

  // Item, operand and ALU result capture.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_item) begin
      cmd_q <= in_data_i.command;
      lit_q <= in_data_i.literal;
    end
    if (ctl_i.cap_en) begin
      case (ctl_i.cap_sel)
        2'd0:    first_q  <= rd_data;
        2'd1:    second_q <= rd_data;
        default: third_q  <= rd_data;
      endcase
    end
    if (ctl_i.alu_en) begin
      res_q <= res_d;
    end
  end

  // Stack addressing relative to the count.
  assign rd_addr = AW'(count_q - CW'(pos_offset(ctl_i.rd_pos)));
  assign wr_addr = AW'(count_q - CW'(pos_offset(ctl_i.wr_pos)));

  always_comb begin
    case (ctl_i.wr_src)
      SRC_LIT:    wr_data = lit_q;
      SRC_FIRST:  wr_data = first_q;
      SRC_SECOND: wr_data = second_q;
      SRC_THIRD:  wr_data = third_q;
      SRC_RES:    wr_data = res_q;
      default:    wr_data = res_q;
    endcase
  end

  fdsa_ram #(
    .WIDTH (32),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (ctl_i.rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  fdsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .is_mod_i   (cmd_q == CMD_MOD),
    .dividend_i (second_q),
    .divisor_i  (first_q),
    .done_o     (div_done),
    .result_o   (div_res)
  );

  // Binary word result: second op first.
  always_comb begin
    case (cmd_q)
      CMD_MUL: res_d = second_q * first_q;
      CMD_ADD: res_d = second_q + first_q;
      CMD_SUB: res_d = second_q - first_q;
      CMD_LT:  res_d = {31'd0, second_q < first_q};
      CMD_GT:  res_d = {31'd0, first_q < second_q};
      CMD_EQ:  res_d = {31'd0, second_q == first_q};
      default: res_d = div_res;
    endcase
  end

  // Stack count update at the end of a word.
  always_comb begin
    count_d = count_q;
    if (ctl_i.fin) begin
      case (ctl_i.cnt_op)
        CNT_INC: count_d = count_q + CW'(1);
        CNT_DEC: count_d = count_q - CW'(1);
        default: count_d = count_q;
      endcase
    end
  end

  always_comb begin
    case (ctl_i.fin_kind)
      PK_NUM:  pval = first_q;
      PK_CHAR: pval = {24'd0, first_q[7:0]};
      default: pval = 32'd0;
    endcase
  end

  // Output register: a finished result waits here while the next beat runs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (ctl_i.fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.fin) begin
      out_data_q.status      <= ctl_i.fin_status;
      out_data_q.print_kind  <= ctl_i.fin_kind;
      out_data_q.print_value <= pval;
      out_data_q.stack_depth <= 7'(count_d);
    end
  end

  assign sts_o.command    = cmd_q;
  assign sts_o.cnt_ge1    = (count_q >= CW'(1));
  assign sts_o.cnt_ge2    = (count_q >= CW'(2));
  assign sts_o.cnt_ge3    = (count_q >= CW'(3));
  assign sts_o.cnt_full   = (count_q >= CW'(STACK_DEPTH));
  assign sts_o.first_zero = (first_q == 32'sd0);
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- rtl/fdsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// fdsa_ctrl: Forth stack controller
// Decodes the word, checks the stack bounds and steps the datapath through
// operand reads, execution, write-back and result delivery.
// ----------------------------------------------------------------------------
module fdsa_ctrl
  import fdsa_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fdsa_sts_t sts_i,
  output fdsa_ctl_t ctl_o
);

  fdsa_state_e  state_q, state_d;
  logic [1:0]   rdk_q, rdk_d;
  logic [1:0]   wrk_q, wrk_d;
  fdsa_status_e st_q, st_d;

  logic         known, grows, is_bin, is_div, enough;
  logic [1:0]   need, nwr;
  fdsa_cnt_e    cnt_op;
  fdsa_kind_e   kind;
  fdsa_pos_e    wpos;
  fdsa_src_e    wsrc;

  // Word decode.
  always_comb begin
    known  = 1'b1;
    grows  = 1'b0;
    is_bin = 1'b0;
    is_div = 1'b0;
    need   = 2'd0;
    nwr    = 2'd0;
    cnt_op = CNT_KEEP;
    kind   = PK_NONE;
    case (sts_i.command)
      CMD_PUSH: begin
        grows = 1'b1; nwr = 2'd1; cnt_op = CNT_INC;
      end
      CMD_DUP: begin
        grows = 1'b1; need = 2'd1; nwr = 2'd1; cnt_op = CNT_INC;
      end
      CMD_OVER: begin
        grows = 1'b1; need = 2'd2; nwr = 2'd1; cnt_op = CNT_INC;
      end
      CMD_MUL, CMD_ADD, CMD_SUB, CMD_LT, CMD_GT, CMD_EQ: begin
        is_bin = 1'b1; need = 2'd2; nwr = 2'd1; cnt_op = CNT_DEC;
      end
      CMD_DIV, CMD_MOD: begin
        is_bin = 1'b1; is_div = 1'b1; need = 2'd2; nwr = 2'd1; cnt_op = CNT_DEC;
      end
      CMD_DROP: begin
        need = 2'd1; cnt_op = CNT_DEC;
      end
      CMD_PRINT: begin
        need = 2'd1; cnt_op = CNT_DEC; kind = PK_NUM;
      end
      CMD_EMIT: begin
        need = 2'd1; cnt_op = CNT_DEC; kind = PK_CHAR;
      end
      CMD_CR: begin
        kind = PK_NL;
      end
      CMD_SWAP: begin
        need = 2'd2; nwr = 2'd2;
      end
      CMD_ROT: begin
        need = 2'd3; nwr = 2'd3;
      end
      default: known = 1'b0;
    endcase
    enough = (need == 2'd0) || (need == 2'd1 && sts_i.cnt_ge1) ||
             (need == 2'd2 && sts_i.cnt_ge2) || (need == 2'd3 && sts_i.cnt_ge3);
  end

  // Write-back schedule for each word.
  always_comb begin
    wpos = POS_TOP;
    wsrc = SRC_RES;
    case (sts_i.command)
      CMD_PUSH: wsrc = SRC_LIT;
      CMD_DUP:  wsrc = SRC_FIRST;
      CMD_OVER: wsrc = SRC_SECOND;
      CMD_SWAP: begin
        wpos = (wrk_q == 2'd0) ? POS_M1 : POS_M2;
        wsrc = (wrk_q == 2'd0) ? SRC_SECOND : SRC_FIRST;
      end
      CMD_ROT: begin
        case (wrk_q)
          2'd0: begin
            wpos = POS_M3; wsrc = SRC_SECOND;
          end
          2'd1: begin
            wpos = POS_M2; wsrc = SRC_FIRST;
          end
          default: begin
            wpos = POS_M1; wsrc = SRC_THIRD;
          end
        endcase
      end
      default: wpos = POS_M2;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdk_q   <= 2'd0;
      wrk_q   <= 2'd0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      rdk_q   <= rdk_d;
      wrk_q   <= wrk_d;
      st_q    <= st_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    rdk_d      = rdk_q;
    wrk_d      = wrk_q;
    st_d       = st_q;
    in_stall_o = 1'b1;
    ctl_o      = '0;
    ctl_o.rd_pos     = POS_M1;
    ctl_o.wr_pos     = wpos;
    ctl_o.wr_src     = wsrc;
    ctl_o.fin_status = st_q;
    ctl_o.fin_kind   = (st_q == ST_OK) ? kind : PK_NONE;
    ctl_o.cnt_op     = (st_q == ST_OK) ? cnt_op : CNT_KEEP;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        ctl_o.ld_item = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        rdk_d = 2'd0;
        wrk_d = 2'd0;
        st_d  = ST_OK;
        if (!known) begin
          state_d = S_DONE;
        end else if (!enough) begin
          st_d    = ST_UNDER;
          state_d = S_DONE;
        end else if (grows && sts_i.cnt_full) begin
          st_d    = ST_OVER;
          state_d = S_DONE;
        end else if (need != 2'd0) begin
          state_d = S_RD_ADDR;
        end else if (nwr != 2'd0) begin
          state_d = S_WR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_RD_ADDR: begin
        ctl_o.rd_en = 1'b1;
        case (rdk_q)
          2'd0:    ctl_o.rd_pos = POS_M1;
          2'd1:    ctl_o.rd_pos = POS_M2;
          default: ctl_o.rd_pos = POS_M3;
        endcase
        state_d = S_RD_DATA;
      end
      S_RD_DATA: begin
        ctl_o.cap_en  = 1'b1;
        ctl_o.cap_sel = rdk_q;
        if (rdk_q == need - 2'd1) begin
          state_d = S_EXEC;
        end else begin
          rdk_d   = rdk_q + 2'd1;
          state_d = S_RD_ADDR;
        end
      end
      S_EXEC: begin
        if (is_div) begin
          if (sts_i.first_zero) begin
            st_d    = ST_DIVZ;
            state_d = S_DONE;
          end else begin
            ctl_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else if (is_bin) begin
          ctl_o.alu_en = 1'b1;
          state_d      = S_WR;
        end else if (nwr != 2'd0) begin
          state_d = S_WR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          ctl_o.alu_en = 1'b1;
          state_d      = S_WR;
        end
      end
      S_WR: begin
        ctl_o.wr_en = 1'b1;
        if (wrk_q == nwr - 2'd1) begin
          state_d = S_DONE;
        end else begin
          wrk_d = wrk_q + 2'd1;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/forth_data_stack_alu_unit.sv -----
// ----------------------------------------------------------------------------
// forth_data_stack_alu_unit: Forth data stack and ALU
// Executes one Forth word per input beat on a bounded stack of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o/in_data_i carries one word (command
//   and literal) per beat. Output channel out_valid_o/out_stall_i/out_data_o
//   returns exactly one result beat per word: status, print kind and value,
//   and the stack depth after the word.
//   Words run one at a time. After acceptance a word passes the bounds
//   check; cr, no-ops and errors found there go on to the result register.
//   Otherwise each operand is read from the stack RAM, address then data,
//   the word executes once operands are read, and each write-back has its
//   own step. Div and mod also run in the bit-serial divider, one quotient
//   bit a cycle; the divider sets the worst case. The next word is accepted
//   the cycle after a result enters the output register.
//   Reset empties the stack and clears both channels; the stack RAM is not
//   cleared, and only entries below the count are ever read.
//   While the receiver stalls, the result holds in the output register; a
//   following word is still accepted and executed, and waits to finish
//   until the register is free.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_unit
  import fdsa_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  fdsa_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output fdsa_out_t out_data_o
);

  fdsa_ctl_t ctl;
  fdsa_sts_t sts;

  fdsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  fdsa_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/fdsa_checker.sv -----
// ----------------------------------------------------------------------------
// fdsa_checker: port-level checks for the Forth data stack and ALU
// Watches the result channel and the reporting rules of the result fields.
// ----------------------------------------------------------------------------
module fdsa_checker
  import fdsa_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input fdsa_out_t out_data_o
);

  // A stalled result beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // A failed word prints nothing.
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.print_kind == PK_NONE && out_data_o.print_value == 32'sd0)
    else $error("error result carries print output");

  // Newline and no output carry a zero value.
  a_nl_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.print_kind == PK_NONE ||
                    out_data_o.print_kind == PK_NL) |->
      out_data_o.print_value == 32'sd0)
    else $error("non-zero value without a printed number");

  // An emitted character fits in one byte.
  a_char_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.print_kind == PK_CHAR |->
      out_data_o.print_value[31:8] == 24'd0)
    else $error("emitted character wider than a byte");

  // The unit takes a new word only after the previous one has reached the
  // output register.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second word accepted while one is in flight");

endmodule

bind forth_data_stack_alu_unit fdsa_checker u_fdsa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sv/forth_data_stack_alu_unit_tb.sv -----
// ----------------------------------------------------------------------------
// forth_data_stack_alu_unit_tb: self-checking bench for the Forth stack ALU
// Drives Forth words on the input channel, models the data stack alongside
// the block and compares every result beat field by field, in order, under
// several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module forth_data_stack_alu_unit_tb;
  import fdsa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;

  // Shadow copy of the stack that predicts each result beat.
  class stack_scoreboard;
    logic [31:0] words[DEPTH];
    int          count;
    fdsa_out_t   pending[$];
    int          mismatches;

    function void clear();
      count = 0;
      mismatches = 0;
      pending.delete();
    endfunction

    // Works out the result of one accepted word and updates the shadow stack.
    function void note_word(fdsa_in_t w);
      fdsa_out_t   res;
      logic [31:0] first, second, third, r, qa, qb;
      int          need;
      bit          grows, binary;
      res = '0;
      need = 0;
      grows = 0;
      binary = 0;
      r = '0;
      case (w.command)
        CMD_PUSH: grows = 1;
        CMD_DUP: begin
          need = 1; grows = 1;
        end
        CMD_OVER: begin
          need = 2; grows = 1;
        end
        CMD_DROP, CMD_PRINT, CMD_EMIT: need = 1;
        CMD_ROT: need = 3;
        CMD_MUL, CMD_DIV, CMD_ADD, CMD_SUB, CMD_MOD, CMD_SWAP,
        CMD_LT, CMD_GT, CMD_EQ: need = 2;
        default: need = 0;
      endcase
      if (w.command <= CMD_EQ) begin
        first = (count >= 1) ? words[count-1] : '0;
        second = (count >= 2) ? words[count-2] : '0;
        if (count < need) begin
          res.status = ST_UNDER;
        end else if (grows && count >= DEPTH) begin
          res.status = ST_OVER;
        end else begin
          binary = 1;
          case (w.command)
            CMD_MUL: r = second * first;
            CMD_ADD: r = second + first;
            CMD_SUB: r = second - first;
            CMD_LT:  r = ($signed(second) < $signed(first)) ? 1 : 0;
            CMD_GT:  r = ($signed(second) > $signed(first)) ? 1 : 0;
            CMD_EQ:  r = (second == first) ? 1 : 0;
            CMD_DIV, CMD_MOD: begin
              if (first == 0) begin
                res.status = ST_DIVZ;
                binary = 0;
              end else begin
                // Magnitudes avoid the most negative over minus one trap.
                qa = second[31] ? -second : second;
                qb = first[31] ? -first : first;
                if (w.command == CMD_DIV) begin
                  r = qa / qb;
                  if (second[31] ^ first[31]) r = -r;
                end else begin
                  r = qa % qb;
                  if (second[31]) r = -r;
                end
              end
            end
            default: binary = 0;
          endcase
          if (binary) begin
            words[count-2] = r;
            count--;
          end else if (res.status == ST_OK) begin
            case (w.command)
              CMD_PUSH: begin
                words[count] = w.literal; count++;
              end
              CMD_DUP: begin
                words[count] = first; count++;
              end
              CMD_OVER: begin
                words[count] = second; count++;
              end
              CMD_DROP: count--;
              CMD_PRINT: begin
                res.print_kind = PK_NUM; res.print_value = first; count--;
              end
              CMD_EMIT: begin
                res.print_kind = PK_CHAR; res.print_value = first & 32'hFF; count--;
              end
              CMD_CR: res.print_kind = PK_NL;
              CMD_SWAP: begin
                words[count-1] = second; words[count-2] = first;
              end
              CMD_ROT: begin
                third = words[count-3];
                words[count-3] = second;
                words[count-2] = first;
                words[count-1] = third;
              end
              default: ;
            endcase
          end
        end
      end
      res.stack_depth = count[6:0];
      pending.push_back(res);
    endfunction

    function void check_result(fdsa_out_t got);
      fdsa_out_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result beat %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.print_kind !== want.print_kind ||
          got.print_value !== want.print_value ||
          got.stack_depth !== want.stack_depth) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: status %0d/%0d kind %0d/%0d value %h/%h depth %0d/%0d (exp/act)",
                   want.status, got.status, want.print_kind, got.print_kind,
                   want.print_value, got.print_value, want.stack_depth, got.stack_depth);
      end
    endfunction
  endclass

  logic      clk_i, rst_ni;
  logic      in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  fdsa_in_t  in_data_i;
  fdsa_out_t out_data_o;

  stack_scoreboard board;
  int          gap_pct, stall_pct;
  int          shadow_depth;

  forth_data_stack_alu_unit #(.STACK_DEPTH(DEPTH)) dut (.*);

  always begin
    clk_i = 1'b1; #6;
    clk_i = 1'b0; #6;
  end

  // Receiver side: random stalls, and every accepted beat is checked.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // Sends one word, keeping the shadow depth used to steer the stimulus.
  // The first falling edge keeps the drive apart from the previous release.
  task automatic send_word(fdsa_cmd_e c, logic [31:0] lit);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i.command <= c;
    in_data_i.literal <= lit;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word('{command: c, literal: lit});
    shadow_depth = board.count;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_raw(logic [4:0] c, logic [31:0] lit);
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i.command <= c;
    in_data_i.literal <= lit;
    do @(posedge clk_i); while (in_stall_o);
    board.note_word('{command: c, literal: lit});
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(3);
      3: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    #30ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    fdsa_cmd_e c;
    board = new();
    board.clear();
    shadow_depth = 0;
    gap_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: underflows on the empty stack, extremes, zero divisors,
    // the most negative dividend, and an unknown command.
    send_word(CMD_DROP, '0);
    send_word(CMD_ROT, '0);
    send_word(CMD_CR, '0);
    send_raw(5'd31, 32'hFFFF_FFFF);
    send_word(CMD_PUSH, 32'h8000_0000);
    send_word(CMD_PUSH, 32'hFFFF_FFFF);
    send_word(CMD_OVER, '0);
    send_word(CMD_OVER, '0);
    send_word(CMD_DIV, '0);
    send_word(CMD_PRINT, '0);
    send_word(CMD_MOD, '0);
    send_word(CMD_PRINT, '0);
    send_word(CMD_PUSH, 32'h7FFF_FFFF);
    send_word(CMD_PUSH, '0);
    send_word(CMD_DIV, '0);
    send_word(CMD_MOD, '0);
    send_word(CMD_LT, '0);
    send_word(CMD_PUSH, 32'h1234_5641);
    send_word(CMD_EMIT, '0);
    send_word(CMD_DUP, '0);
    send_word(CMD_GT, '0);
    send_word(CMD_EQ, '0);
    send_word(CMD_ROT, '0);
    send_word(CMD_SWAP, '0);
    drain();

    // Fill to the top to provoke overflow on push, dup and over.
    while (shadow_depth < DEPTH) send_word(CMD_PUSH, $urandom());
    send_word(CMD_PUSH, '0);
    send_word(CMD_DUP, '0);
    send_word(CMD_OVER, '0);
    send_word(CMD_MUL, '0);
    send_word(CMD_SUB, '0);
    send_word(CMD_ADD, '0);

    // Random words in four idling phases, depth kept mostly mid-range.
    for (int ph = 0; ph < 4; ph++) begin
      gap_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 54 : 17) : 0;
      stall_pct = (ph == 2) ? 54 : ((ph == 3) ? 17 : 0);
      for (int i = 0; i < 480; i++) begin
        if ($urandom_range(19) == 0) begin
          send_raw(5'($urandom_range(17, 31)), $urandom());
        end else begin
          if (shadow_depth < 3 && $urandom_range(1)) c = CMD_PUSH;
          else if (shadow_depth > DEPTH - 3 && $urandom_range(1)) c = CMD_DROP;
          else c = fdsa_cmd_e'(5'($urandom_range(16)));
          send_word(c, rand_value());
        end
      end
      drain();
    end
    repeat (60) @(negedge clk_i);

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
